// ----- rtl/bfv_pkg.sv -----
// bfv_pkg: shared constants and bus types for the box visibility pipeline.
// No dependencies.
package bfv_pkg;

   localparam int COORD_W  = 32;             // Q16.16 box coordinate / matrix entry
   localparam int PROD_W   = 2 * COORD_W;    // exact Q32.32 product
   localparam int Q_W      = 50;             // clip-space component, full width
   localparam int CMP_W    = Q_W + 18;       // room for 65536*v and 65537*w
   localparam int ROWS     = 4;
   localparam int AXES     = 3;
   localparam int CORNERS  = 8;
   localparam int FRAC_W   = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_R0_C01 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_R0_C23 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_R1_C01 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_R1_C23 = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_R2_C01 = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_R2_C23 = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_R3_C01 = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAT_R3_C23 = 4'd7;

   localparam logic [COORD_W-1:0] Q_ONE = 32'h0001_0000;

   // matrix [row][col], each entry signed Q16.16
   typedef logic [ROWS-1:0][ROWS-1:0][COORD_W-1:0] mat_type;
   // clip-space result of every corner: [corner][row]
   typedef logic [CORNERS-1:0][ROWS-1:0][Q_W-1:0] qbus_type;

   // reset matrix: identity, rows listed from 3 down to 0
   localparam mat_type MAT_IDENTITY = {
      {Q_ONE, 32'h0, 32'h0, 32'h0},
      {32'h0, Q_ONE, 32'h0, 32'h0},
      {32'h0, 32'h0, Q_ONE, 32'h0},
      {32'h0, 32'h0, 32'h0, Q_ONE}
   };

endpackage

// ----- rtl/bfv_xform.sv -----
// bfv_xform: matrix transform of all eight box corners, two register stages.
// Depends on bfv_pkg.
module bfv_xform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [bfv_pkg::COORD_W-1:0]   box_min [bfv_pkg::AXES],
   input  logic signed [bfv_pkg::COORD_W-1:0]   box_max [bfv_pkg::AXES],
   input  bfv_pkg::mat_type                     mat,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output bfv_pkg::qbus_type                    q_o
);

   // stage 1: products, [sel: 0=max 1=min][row][col]
   logic signed [bfv_pkg::PROD_W-1:0] prod_ff [2][bfv_pkg::ROWS][bfv_pkg::AXES];
   logic signed [bfv_pkg::PROD_W-1:0] prod_in [2][bfv_pkg::ROWS][bfv_pkg::AXES];
   logic                              v1_ff, v1_in;
   logic                              r1, r2;
   // stage 2: per-corner sums
   bfv_pkg::qbus_type                 q_ff, q_in;
   logic                              v2_ff, v2_in;

   assign r2       = !v2_ff || out_ready;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   // 32x32 signed products, sign-extended to the full product width
   always_comb begin
      for (int r = 0; r < bfv_pkg::ROWS; r++) begin
         for (int k = 0; k < bfv_pkg::AXES; k++) begin
            prod_in[0][r][k] = bfv_pkg::PROD_W'($signed(mat[r][k]))
                             * bfv_pkg::PROD_W'(box_max[k]);
            prod_in[1][r][k] = bfv_pkg::PROD_W'($signed(mat[r][k]))
                             * bfv_pkg::PROD_W'(box_min[k]);
         end
      end
   end

   // floor(m*p / 2^16) is an arithmetic shift of the exact product
   always_comb begin
      logic signed [bfv_pkg::Q_W-1:0] acc;
      for (int c = 0; c < bfv_pkg::CORNERS; c++) begin
         for (int r = 0; r < bfv_pkg::ROWS; r++) begin
            acc = bfv_pkg::Q_W'($signed(mat[r][bfv_pkg::ROWS-1]));
            for (int k = 0; k < bfv_pkg::AXES; k++) begin
               acc = acc + bfv_pkg::Q_W'($signed(
                  prod_ff[c[k]][r][k][bfv_pkg::PROD_W-1:bfv_pkg::FRAC_W]));
            end
            q_in[c][r] = acc;
         end
      end
   end

   assign v1_in = r1 ? in_valid : v1_ff;
   assign v2_in = r2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (r1 && in_valid) prod_ff <= prod_in;
      if (r2 && v1_ff)    q_ff    <= q_in;
   end

   assign out_valid = v2_ff;
   assign q_o       = q_ff;

endmodule

// ----- rtl/bfv_clip.sv -----
// bfv_clip: per-corner cube-bound compares and final visibility reduce.
// Depends on bfv_pkg.
module bfv_clip (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bfv_pkg::qbus_type  q,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_visible
);

   // n <= 1  <=>  65536*v <  65537*w ;  n >= -1 <=> 65536*v + 65537*w > 0
   logic [bfv_pkg::CORNERS-1:0]                  front_ff, front_in;
   logic [bfv_pkg::CORNERS-1:0][bfv_pkg::AXES-1:0] lo_ok_ff, lo_ok_in, hi_ok_ff, hi_ok_in;
   logic v3_ff, v3_in, v4_ff, v4_in, r3, r4;
   logic vis_ff, vis_in;

   assign r4       = !v4_ff || rsp_ready;
   assign r3       = !v3_ff || r4;
   assign in_ready = r3;

   always_comb begin
      logic signed [bfv_pkg::CMP_W-1:0] w, v, lhs, rhs;
      for (int c = 0; c < bfv_pkg::CORNERS; c++) begin
         w   = bfv_pkg::CMP_W'($signed(q[c][bfv_pkg::ROWS-1]));
         rhs = (w <<< bfv_pkg::FRAC_W) + w;
         front_in[c] = (w > 0);
         for (int a = 0; a < bfv_pkg::AXES; a++) begin
            v   = bfv_pkg::CMP_W'($signed(q[c][a]));
            lhs = v <<< bfv_pkg::FRAC_W;
            lo_ok_in[c][a] = front_in[c] && (lhs < rhs);
            hi_ok_in[c][a] = front_in[c] && ((lhs + rhs) > 0);
         end
      end
   end

   always_comb begin
      logic [bfv_pkg::AXES-1:0] lo_any, hi_any;
      lo_any = '0;
      hi_any = '0;
      for (int c = 0; c < bfv_pkg::CORNERS; c++) begin
         lo_any = lo_any | lo_ok_ff[c];
         hi_any = hi_any | hi_ok_ff[c];
      end
      vis_in = (|front_ff) && (&lo_any) && (&hi_any);
   end

   assign v3_in = r3 ? in_valid : v3_ff;
   assign v4_in = r4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
      if (r3 && in_valid) begin
         front_ff <= front_in;
         lo_ok_ff <= lo_ok_in;
         hi_ok_ff <= hi_ok_in;
      end
      if (r4 && v3_ff) vis_ff <= vis_in;
   end

   assign rsp_valid   = v4_ff;
   assign rsp_visible = vis_ff;

   a_no_front_culled: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && r4 && !(|front_ff)) |=> !rsp_visible)
      else $error("box with no front corner reported visible");
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !r4) |=> (v3_ff && $stable(front_ff) && $stable(lo_ok_ff)))
      else $error("stage 3 changed while stalled");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!v3_ff && !v4_ff))
      else $error("pipeline not empty after reset");

endmodule

// ----- rtl/box_frustum_visibility_test_unit.sv -----
// box_frustum_visibility_test_unit: top level, matrix registers and pipeline.
// Depends on bfv_pkg, bfv_xform, bfv_clip.
//
//  channel  dir  ports                          beat
//  req      in   req_valid/ready, req_box_*     one box (six Q16.16 bounds)
//  rsp      out  rsp_valid/ready, rsp_visible   one verdict per box
//  csr      in   csr_valid/ready, index, data   one 64-bit matrix register
//
// Four register stages: products, corner sums, bound compares, reduce.
// One box per cycle sustained while rsp_ready stays high; rsp_valid rises
// once the box has passed the product, sum, compare and reduce registers.
// Each stage holds under backpressure and takes new data when empty, so a
// waiting rsp beat does not block req while bubbles remain upstream.
// Synchronous reset empties the pipeline and loads the identity matrix.
// csr is always ready; indexes above seven are dropped.
module box_frustum_visibility_test_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [bfv_pkg::COORD_W-1:0] req_box_min_x,
   input  logic signed [bfv_pkg::COORD_W-1:0] req_box_min_y,
   input  logic signed [bfv_pkg::COORD_W-1:0] req_box_min_z,
   input  logic signed [bfv_pkg::COORD_W-1:0] req_box_max_x,
   input  logic signed [bfv_pkg::COORD_W-1:0] req_box_max_y,
   input  logic signed [bfv_pkg::COORD_W-1:0] req_box_max_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_visible,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bfv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfv_pkg::CSR_DATA_W-1:0]     csr_data
);

   bfv_pkg::mat_type  mat_ff, mat_in;
   logic              xf_valid;
   bfv_pkg::qbus_type q_bus;
   logic              clip_ready;
   logic signed [bfv_pkg::COORD_W-1:0] box_min [bfv_pkg::AXES];
   logic signed [bfv_pkg::COORD_W-1:0] box_max [bfv_pkg::AXES];

   assign box_min[0] = req_box_min_x;
   assign box_min[1] = req_box_min_y;
   assign box_min[2] = req_box_min_z;
   assign box_max[0] = req_box_max_x;
   assign box_max[1] = req_box_max_y;
   assign box_max[2] = req_box_max_z;

   assign csr_ready = 1'b1;

   // index bits: [2:1] row, [0] column pair
   always_comb begin
      mat_in = mat_ff;
      if (csr_valid && (csr_index <= bfv_pkg::CSR_MAT_R3_C23)) begin
         mat_in[csr_index[2:1]][{csr_index[0], 1'b0}] = csr_data[31:0];
         mat_in[csr_index[2:1]][{csr_index[0], 1'b1}] = csr_data[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= bfv_pkg::MAT_IDENTITY;
      end else begin
         mat_ff <= mat_in;
      end
   end

   bfv_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .box_min   (box_min),
      .box_max   (box_max),
      .mat       (mat_ff),
      .out_valid (xf_valid),
      .out_ready (clip_ready),
      .q_o       (q_bus)
   );

   bfv_clip u_clip (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (xf_valid),
      .in_ready    (clip_ready),
      .q           (q_bus),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_visible (rsp_visible)
   );

   a_csr_r0: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == bfv_pkg::CSR_MAT_R0_C01)
      |=> (mat_ff[0][0] == $past(csr_data[31:0])))
      else $error("matrix entry not written");

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for box_frustum_visibility_test_unit.
// Predicts each verdict from the matrix registers and the box corners in
// Q16.16 fixed point; depends on bfv_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;

   localparam int PERIOD_NS = 4;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [bfv_pkg::CSR_IDX_W-1:0] CSR_IDX_BAD = 4'd12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [bfv_pkg::COORD_W-1:0] req_box_min_x = '0, req_box_min_y = '0;
   logic signed [bfv_pkg::COORD_W-1:0] req_box_min_z = '0;
   logic signed [bfv_pkg::COORD_W-1:0] req_box_max_x = '0, req_box_max_y = '0;
   logic signed [bfv_pkg::COORD_W-1:0] req_box_max_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_visible;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bfv_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bfv_pkg::CSR_DATA_W-1:0] csr_data = '0;

   box_frustum_visibility_test_unit dut (.*);

   initial begin
      forever #(PERIOD_NS / 2) clock = ~clock;
   end

   typedef struct {
      logic signed [bfv_pkg::COORD_W-1:0] lo [bfv_pkg::AXES];
      logic signed [bfv_pkg::COORD_W-1:0] hi [bfv_pkg::AXES];
   } box_type;

   // directed row: box, expected verdict, and whether that verdict is typed in
   typedef struct {
      box_type box;
      bit      known;
      bit      vis;
   } row_type;

   // predictor's own copy of the matrix, [row][col], sign-extended Q16.16
   longint mirror_mat [bfv_pkg::ROWS][bfv_pkg::ROWS];
   bit     verdict_q [$];
   bit     failed = 1'b0;

   function automatic longint mul_floor(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return p / 65536;
      return -((-p + 65535) / 65536);
   endfunction

   // trunc(v * 2^16 / w), w > 0, saturated to signed 32 bits
   function automatic longint div_exact(longint v, longint w);
      longint av, ip, rem, mag;
      av = (v < 0) ? -v : v;
      ip = av / w;
      if (ip >= 32768) mag = 64'sd2147483648;
      else begin
         rem = av % w;
         mag = ip * 65536;
         for (int k = 15; k >= 0; k--) begin
            rem = rem * 2;
            if (rem >= w) begin
               rem = rem - w;
               mag = mag + (64'sd1 <<< k);
            end
         end
      end
      if (v >= 0) return (mag > 64'sd2147483647) ? 64'sd2147483647 : mag;
      return -mag;
   endfunction

   function automatic bit predict_visible(box_type b);
      longint lo [bfv_pkg::AXES], hi [bfv_pkg::AXES], pt [bfv_pkg::AXES];
      longint q [bfv_pkg::ROWS], n;
      bit any, vis;
      any = 1'b0;
      for (int a = 0; a < bfv_pkg::AXES; a++) begin
         lo[a] = 0;
         hi[a] = 0;
      end
      for (int c = 0; c < bfv_pkg::CORNERS; c++) begin
         for (int a = 0; a < bfv_pkg::AXES; a++)
            pt[a] = c[a] ? longint'(b.lo[a]) : longint'(b.hi[a]);
         for (int r = 0; r < bfv_pkg::ROWS; r++)
            q[r] = mul_floor(mirror_mat[r][0], pt[0]) + mul_floor(mirror_mat[r][1], pt[1])
                 + mul_floor(mirror_mat[r][2], pt[2]) + mirror_mat[r][3];
         if (q[3] > 0) begin
            for (int a = 0; a < bfv_pkg::AXES; a++) begin
               n = div_exact(q[a], q[3]);
               if (!any || n < lo[a]) lo[a] = n;
               if (!any || n > hi[a]) hi[a] = n;
            end
            any = 1'b1;
         end
      end
      vis = any;
      for (int a = 0; a < bfv_pkg::AXES; a++)
         if (lo[a] > 65536 || hi[a] < -65536) vis = 1'b0;
      return vis;
   endfunction

   // ---------------------------------------------------------------------
   // csr write; only called with the pipeline drained
   task automatic write_reg(logic [bfv_pkg::CSR_IDX_W-1:0] idx,
                            logic [bfv_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx <= bfv_pkg::CSR_MAT_R3_C23) begin
         mirror_mat[idx >> 1][(idx & 1) * 2]     = longint'(signed'(data[31:0]));
         mirror_mat[idx >> 1][(idx & 1) * 2 + 1] = longint'(signed'(data[63:32]));
      end
      @(posedge clock);
   endtask

   // stop sending, wait out every pending verdict plus pipeline depth
   task automatic drain;
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves req_valid high after the beat; drain or a call with a gap drops it
   task automatic send_box(box_type b, bit known, bit vis);
      bit want;
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_box_min_x <= b.lo[0];
      req_box_min_y <= b.lo[1];
      req_box_min_z <= b.lo[2];
      req_box_max_x <= b.hi[0];
      req_box_max_y <= b.hi[1];
      req_box_max_z <= b.hi[2];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = predict_visible(b);
      if (known && want != vis) begin
         $display("%0t: predictor disagrees with table row: table %0b predictor %0b",
                  $time, vis, want);
         failed = 1'b1;
      end
      verdict_q.push_back(known ? vis : want);
   endtask

   // receiver: random stall per beat, compare against the oldest expectation
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict beat, actual visible=%0b", $time, rsp_visible);
            failed = 1'b1;
         end else begin
            bit want;
            want = verdict_q.pop_front();
            if (rsp_visible !== want) begin
               $display("%0t: visible mismatch: expected %0b actual %0b",
                        $time, want, rsp_visible);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic box_type mk(int x0, int y0, int z0, int x1, int y1, int z1);
      box_type b;
      b.lo[0] = x0; b.lo[1] = y0; b.lo[2] = z0;
      b.hi[0] = x1; b.hi[1] = y1; b.hi[2] = z1;
      return b;
   endfunction

   // random coordinate: within +-0.75, +-2 or +-32, or full range, equally often
   function automatic logic signed [bfv_pkg::COORD_W-1:0] rand_coord;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0004_0000) - 32'sh0002_0000;
         2: return $urandom_range(0, 32'h0040_0000) - 32'sh0020_0000;
         default: return $urandom_range(0, 32'h0001_8000) - 32'sh0000_c000;
      endcase
   endfunction

   function automatic box_type rand_box;
      box_type b;
      logic signed [bfv_pkg::COORD_W-1:0] a0, a1;
      for (int a = 0; a < bfv_pkg::AXES; a++) begin
         a0 = rand_coord();
         a1 = rand_coord();
         // mostly ordered boxes; some inverted on purpose
         if ($urandom_range(0, 7) != 0 && a0 > a1) begin
            b.lo[a] = a1; b.hi[a] = a0;
         end else begin
            b.lo[a] = a0; b.hi[a] = a1;
         end
      end
      return b;
   endfunction

   // random matrix entry: small perspective-ish values or raw noise
   function automatic logic [31:0] rand_entry;
      if ($urandom_range(0, 4) == 0) return $urandom();
      return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
   endfunction

   task automatic rand_matrix;
      for (int i = 0; i <= bfv_pkg::CSR_MAT_R3_C23; i++)
         write_reg(i[bfv_pkg::CSR_IDX_W-1:0], {rand_entry(), rand_entry()});
   endtask

   // perspective-like: w = z + 2 so boxes near origin are in front
   task automatic persp_matrix;
      write_reg(bfv_pkg::CSR_MAT_R0_C01, {32'h0, 32'h0001_0000});
      write_reg(bfv_pkg::CSR_MAT_R0_C23, 64'h0);
      write_reg(bfv_pkg::CSR_MAT_R1_C01, {32'h0001_0000, 32'h0});
      write_reg(bfv_pkg::CSR_MAT_R1_C23, 64'h0);
      write_reg(bfv_pkg::CSR_MAT_R2_C01, 64'h0);
      write_reg(bfv_pkg::CSR_MAT_R2_C23, {32'h0, 32'h0000_8000});
      write_reg(bfv_pkg::CSR_MAT_R3_C01, 64'h0);
      write_reg(bfv_pkg::CSR_MAT_R3_C23, {32'h0002_0000, 32'h0001_0000});
   endtask

   localparam int ONE = 32'h0001_0000;
   localparam int MAXI = 32'h7fff_ffff;
   localparam int MINI = 32'h8000_0000;

   row_type rows [] = '{
      '{mk(0, 0, 0, 0, 0, 0), 1, 1},                          // point at origin
      '{mk(-ONE, -ONE, -ONE, ONE, ONE, ONE), 1, 1},          // the cube itself
      '{mk(ONE, ONE, ONE, ONE, ONE, ONE), 1, 1},             // touching corner
      '{mk(ONE + 1, 0, 0, ONE + 1, 0, 0), 1, 0},             // just outside x
      '{mk(0, -ONE - 1, 0, 0, -ONE - 1, 0), 1, 0},           // just outside y
      '{mk(0, 0, 3 * ONE, 0, 0, 4 * ONE), 1, 0},             // far in z
      '{mk(MINI, MINI, MINI, MAXI, MAXI, MAXI), 1, 1},       // full range
      '{mk(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI), 1, 0},       // max corner only
      '{mk(MINI, MINI, MINI, MINI, MINI, MINI), 1, 0},       // min corner only
      '{mk(ONE, ONE, ONE, -ONE, -ONE, -ONE), 1, 1},          // inverted bounds
      '{mk(5 * ONE, 0, 0, -5 * ONE, 0, 0), 1, 1},            // inverted, spans
      '{mk(-1, -1, -1, -1, -1, -1), 0, 0},
      '{mk(2 * ONE, 2 * ONE, 0, 3 * ONE, 3 * ONE, 0), 1, 0}
   };

   // with the perspective matrix: boxes behind, straddling and in front
   row_type persp_rows [] = '{
      '{mk(0, 0, -5 * ONE, 0, 0, -4 * ONE), 1, 0},           // all corners behind
      '{mk(0, 0, -2 * ONE, 0, 0, -2 * ONE), 1, 0},           // w exactly zero
      '{mk(0, 0, -3 * ONE, 0, 0, 0), 0, 0},                  // straddles camera
      '{mk(MINI, MINI, -ONE - 1, MAXI, MAXI, -ONE - 1), 0, 0}, // quotient saturates
      '{mk(MAXI, 0, MINI, MAXI, 0, MAXI), 0, 0},
      '{mk(-ONE, -ONE, 0, ONE, ONE, ONE), 0, 0}
   };

   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < bfv_pkg::ROWS; r++)
         for (int c = 0; c < bfv_pkg::ROWS; c++)
            mirror_mat[r][c] = (r == c) ? 65536 : 0;

      // identity matrix after reset
      foreach (rows[i]) send_box(rows[i].box, rows[i].known, rows[i].vis);
      drain();

      persp_matrix();
      write_reg(CSR_IDX_BAD, 64'hdead_beef_dead_beef);   // dropped index
      foreach (persp_rows[i])
         send_box(persp_rows[i].box, persp_rows[i].known, persp_rows[i].vis);
      drain();

      // extremes of every register: all ones, then max positive (even index) or most negative (odd index)
      for (int i = 0; i <= bfv_pkg::CSR_MAT_R3_C23; i++)
         write_reg(i[bfv_pkg::CSR_IDX_W-1:0], '1);
      for (int k = 0; k < 20; k++) send_box(rand_box(), 0, 0);
      drain();
      for (int i = 0; i <= bfv_pkg::CSR_MAT_R3_C23; i++)
         write_reg(i[bfv_pkg::CSR_IDX_W-1:0], (i % 2) ? 64'h8000_0000_8000_0000
                                                     : 64'h7fff_ffff_7fff_ffff);
      for (int k = 0; k < 20; k++) send_box(rand_box(), 0, 0);
      drain();

      // random phases: mostly perspective-like matrices, some raw noise
      for (int ph = 0; ph < 13; ph++) begin
         case (ph % 3)
            0: persp_matrix();
            1: rand_matrix();
            default: begin
               for (int i = 0; i <= bfv_pkg::CSR_MAT_R3_C23; i++)
                  write_reg(i[bfv_pkg::CSR_IDX_W-1:0], 64'h0);
               persp_matrix();
               write_reg(bfv_pkg::CSR_MAT_R0_C23, {rand_entry(), rand_entry()});
               write_reg(bfv_pkg::CSR_MAT_R1_C23, {rand_entry(), rand_entry()});
            end
         endcase
         for (int k = 0; k < 100; k++) begin
            send_box(rand_box(), 0, 0);
            // hold-off: let the pipe run dry mid-phase
            if (k == 50) drain();
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && verdict_q.size() == 0)
         $display("** box_frustum_visibility_test_unit: PASSED **");
      else begin
         if (verdict_q.size() != 0)
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
         $display("** box_frustum_visibility_test_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #(PERIOD_NS * 400000);
      $display("%0t: timeout", $time);
      $display("** box_frustum_visibility_test_unit: FAILED **");
      $finish;
   end

endmodule

// ----- box_frustum_visibility_test_unit.f -----
rtl/bfv_pkg.sv
rtl/bfv_xform.sv
rtl/bfv_clip.sv
rtl/box_frustum_visibility_test_unit.sv
tb/tb.sv
